// ----- rtl/core/gled_pkg.sv -----
// Shared types and constants for the grid local extremum detector.
// Used by gled_classify, gled_out_fifo, the core top level and the bench; depends on nothing.
package gled_pkg;

  localparam int MAX_COLS_DEF     = 1024;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int GRID_DIM_RESET   = 1024;

  localparam int CFG_WIDTH       = 11;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_COLS = 2'd1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam int ROW_OUT_WIDTH = 10;
  localparam int COL_OUT_WIDTH = 10;
  localparam int KIND_WIDTH    = 2;
  localparam logic [KIND_WIDTH-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_MIN  = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_MAX  = 2'd2;

  localparam int OUT_FIFO_DEPTH = 4;

  typedef struct packed {
    logic                     classify;
    logic                     write;
    logic                     up_ok;
    logic                     down_ok;
    logic                     left_ok;
    logic                     right_ok;
    logic                     last;
    logic [ROW_OUT_WIDTH-1:0] row;
    logic [COL_OUT_WIDTH-1:0] col;
  } gled_ctrl_t;

  typedef struct packed {
    logic [ROW_OUT_WIDTH-1:0] cell_row;
    logic [COL_OUT_WIDTH-1:0] cell_col;
    logic [KIND_WIDTH-1:0]    kind;
    logic                     frame_last;
  } gled_result_t;

endpackage

// ----- rtl/core/gled_line_ram.sv -----
// Column line buffer: one write port, two registered read ports.
// A read in the cycle of a write to the same entry returns the new word.
module gled_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] q_a;
  logic [DW-1:0] q_b;
  logic [DW-1:0] byp_data;
  logic          byp_a;
  logic          byp_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a      <= mem[rd_addr_a];
    q_b      <= mem[rd_addr_b];
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_a <= 1'b0;
      byp_b <= 1'b0;
    end else begin
      byp_a <= wr_en && (wr_addr == rd_addr_a);
      byp_b <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  assign rd_data_a = byp_a ? byp_data : q_a;
  assign rd_data_b = byp_b ? byp_data : q_b;

endmodule

// ----- rtl/core/gled_classify.sv -----
// Window stage: takes line buffer words, compares the center cell with its four
// neighbors and issues the write-back of the column. Depends on gled_pkg.
module gled_classify #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int AW           = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gled_pkg::gled_ctrl_t             ctrl_in,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_value,
  input  logic                             sample_valid,
  input  logic [AW-1:0]                    addr,
  input  logic [2*(SAMPLE_WIDTH+1)-1:0]    rd_data_a,
  input  logic [2*(SAMPLE_WIDTH+1)-1:0]    rd_data_b,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [2*(SAMPLE_WIDTH+1)-1:0]    wr_data,
  output logic                             res_valid,
  output gled_pkg::gled_result_t           res
);
  import gled_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;

  gled_ctrl_t                     s1_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] s1_value;
  logic                           s1_valid;
  logic [AW-1:0]                  s1_addr;
  logic signed [SAMPLE_WIDTH-1:0] left_value;
  logic                           left_valid;

  logic [EW-1:0]                  center;
  logic [EW-1:0]                  up;
  logic [EW-1:0]                  right;
  logic signed [SAMPLE_WIDTH-1:0] ctr_value;
  logic signed [SAMPLE_WIDTH-1:0] nb_value [4];
  logic                           nb_use [4];
  logic                           lo;
  logic                           hi;
  logic [KIND_WIDTH-1:0]          kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else begin
      s1_ctrl <= ctrl_in;
    end
    s1_value <= sample_value;
    s1_valid <= sample_valid;
    s1_addr  <= addr;
    if (s1_ctrl.classify) begin
      left_value <= ctr_value;
      left_valid <= center[EW-1];
    end
  end

  assign center    = rd_data_a[2*EW-1:EW];
  assign up        = rd_data_a[EW-1:0];
  assign right     = rd_data_b[2*EW-1:EW];
  assign ctr_value = center[SAMPLE_WIDTH-1:0];

  always_comb begin
    nb_value[0] = up[SAMPLE_WIDTH-1:0];
    nb_use[0]   = s1_ctrl.up_ok && up[EW-1];
    nb_value[1] = s1_value;
    nb_use[1]   = s1_ctrl.down_ok && s1_valid;
    nb_value[2] = left_value;
    nb_use[2]   = s1_ctrl.left_ok && left_valid;
    nb_value[3] = right[SAMPLE_WIDTH-1:0];
    nb_use[3]   = s1_ctrl.right_ok && right[EW-1];
    lo = 1'b1;
    hi = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (nb_use[i]) begin
        if (!(ctr_value < nb_value[i])) lo = 1'b0;
        if (!(ctr_value > nb_value[i])) hi = 1'b0;
      end
    end
    if (!center[EW-1]) begin
      kind = KIND_NONE;
    end else if (lo) begin
      kind = KIND_MIN;
    end else if (hi) begin
      kind = KIND_MAX;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign wr_en   = s1_ctrl.write;
  assign wr_addr = s1_addr;
  assign wr_data = {s1_valid, s1_value, center};

  assign res_valid      = s1_ctrl.classify;
  assign res.cell_row   = s1_ctrl.row;
  assign res.cell_col   = s1_ctrl.col;
  assign res.kind       = kind;
  assign res.frame_last = s1_ctrl.last;

endmodule

// ----- rtl/core/gled_out_fifo.sv -----
// Result queue with credit toward beats still in flight in the window stage.
// Depends on gled_pkg for the result type.
module gled_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gled_pkg::gled_result_t push_data,
  input  logic                   pending,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gled_pkg::gled_result_t pop_data
);
  import gled_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  gled_result_t    entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            pop;

  assign pop       = (count != '0) && !out_stall;
  assign out_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign room      = (({1'b0, count} + (CNTW+1)'(pending)) < (CNTW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/grid_local_extremum_detector_core.sv -----
// Grid local extremum detector, top level: raster counters, configuration,
// line buffer, window stage and result queue. Depends on gled_pkg.
//
// Usage: samples of one frame arrive in raster order on the input channel
// (op = sample), one beat each; after the last sample, grid_cols flush beats
// (op = flush) drain the last row. A sample beat at raster position k gives a
// result beat for cell k - grid_cols; the first row gives none. A flush beat
// before the frame is full, and a sample beat into a full frame, are dropped.
// The final flush marks frame_last and restarts the frame.
// Throughput: one input beat per cycle while in_stall is low. An accepted
// input beat reaches the result output through the line buffer read, then
// compare and queue write. The line buffer holds two samples per column and
// does one read-modify-write per sample beat, with bypass on back-to-back
// access.
// The receiver may stall at will: a four-entry result queue holds finished
// beats and input stall rises only when the queue could overflow.
// Configuration writes set grid_rows or grid_cols (clamped to 1..MAX) and
// restart the frame; write them only while the block is idle.
// Reset: both dimensions go to 1024 (clamped), counters and queue clear; the
// line buffer needs no clearing.
module grid_local_extremum_detector_core #(
  parameter int MAX_COLS     = gled_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS     = gled_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_WIDTH = gled_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [gled_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [gled_pkg::CFG_WIDTH-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_value,
  input  logic                                  sample_valid,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [gled_pkg::ROW_OUT_WIDTH-1:0]    cell_row,
  output logic [gled_pkg::COL_OUT_WIDTH-1:0]    cell_col,
  output logic [gled_pkg::KIND_WIDTH-1:0]       kind,
  output logic                                  frame_last
);
  import gled_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int RESET_ROWS = (GRID_DIM_RESET > MAX_ROWS) ? MAX_ROWS : GRID_DIM_RESET;
  localparam int RESET_COLS = (GRID_DIM_RESET > MAX_COLS) ? MAX_COLS : GRID_DIM_RESET;

  logic [RW-1:0]  grid_rows;
  logic [CW-1:0]  grid_cols;
  logic [RW-1:0]  in_row;
  logic [CW-1:0]  in_col;
  logic [RW-1:0]  rows_cfg;
  logic [CW-1:0]  cols_cfg;
  logic           cfg_restart;

  logic           in_fire;
  logic           frame_full;
  logic           is_sample;
  logic           take_sample;
  logic           take_flush;
  logic           col_last;
  gled_ctrl_t     ctrl;
  logic [AW-1:0]  rd_addr_a;
  logic [AW-1:0]  rd_addr_b;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [2*EW-1:0] wr_data;
  logic [2*EW-1:0] rd_data_a;
  logic [2*EW-1:0] rd_data_b;
  logic           res_valid;
  gled_result_t   res;
  gled_result_t   pop_data;
  logic           room;

  always_comb begin
    if (cfg_data == '0) begin
      rows_cfg = RW'(1);
    end else if (32'(cfg_data) > MAX_ROWS) begin
      rows_cfg = RW'(MAX_ROWS);
    end else begin
      rows_cfg = RW'(cfg_data);
    end
    if (cfg_data == '0) begin
      cols_cfg = CW'(1);
    end else if (32'(cfg_data) > MAX_COLS) begin
      cols_cfg = CW'(MAX_COLS);
    end else begin
      cols_cfg = CW'(cfg_data);
    end
  end

  assign cfg_restart = cfg_write && ((cfg_index == REG_GRID_ROWS) ||
                                     (cfg_index == REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= RW'(RESET_ROWS);
      grid_cols <= CW'(RESET_COLS);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= rows_cfg;
        REG_GRID_COLS: grid_cols <= cols_cfg;
        default: ;
      endcase
    end
  end

  assign in_stall    = !room;
  assign in_fire     = in_valid && !in_stall;
  assign frame_full  = (in_row >= grid_rows);
  assign is_sample   = (op == OP_SAMPLE);
  assign take_sample = in_fire && is_sample && !frame_full;
  assign take_flush  = in_fire && (op == OP_FLUSH) && frame_full;
  assign col_last    = ((in_col + CW'(1)) == grid_cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (cfg_restart) begin
      in_row <= '0;
      in_col <= '0;
    end else if (take_sample) begin
      if (col_last) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end else if (take_flush) begin
      if (col_last) begin
        in_row <= '0;
        in_col <= '0;
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  always_comb begin
    ctrl.classify = (take_sample && (in_row != '0)) || take_flush;
    ctrl.write    = take_sample;
    ctrl.up_ok    = (32'(in_row) >= 2);
    ctrl.down_ok  = is_sample;
    ctrl.left_ok  = (in_col != '0);
    ctrl.right_ok = !col_last;
    ctrl.last     = take_flush && col_last;
    ctrl.row      = ROW_OUT_WIDTH'(in_row - RW'(1));
    ctrl.col      = COL_OUT_WIDTH'(in_col);
  end

  assign rd_addr_a = in_col[AW-1:0];
  assign rd_addr_b = (32'(in_col) + 1 >= MAX_COLS) ? '0 : AW'(in_col + CW'(1));

  gled_line_ram #(
    .DEPTH (MAX_COLS),
    .AW    (AW),
    .DW    (2*EW)
  ) u_line_ram (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  gled_classify #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .ctrl_in      (ctrl),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .addr         (rd_addr_a),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_valid    (res_valid),
    .res          (res)
  );

  gled_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pending   (res_valid),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pop_data  (pop_data)
  );

  assign cell_row   = pop_data.cell_row;
  assign cell_col   = pop_data.cell_col;
  assign kind       = pop_data.kind;
  assign frame_last = pop_data.frame_last;

endmodule

// ----- bench/tb_grid_local_extremum_detector_core.sv -----
// Testbench for grid_local_extremum_detector_core: a directed table, then random frames,
// all checked beat by beat against an in-bench model of the classifier or typed cells.
// Depends on gled_pkg and the core RTL; needs no files or arguments.
module tb_grid_local_extremum_detector_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gled_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int STORE_DEPTH = 2 * MAX_COLS_DEF + 1;
  localparam int ITEM_TARGET  = 1350;
  localparam int BIG_BUDGET   = 150;
  localparam int PAUSE_AT     = 500;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 80;
  localparam int WIDE_PHASE   = 3;
  localparam int TALL_PHASE   = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;
  localparam logic signed [SW-1:0] VALUE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] VALUE_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_mode_t;

  typedef struct {
    bit                          is_cfg;
    logic [CFG_INDEX_WIDTH-1:0]  idx;
    logic [CFG_WIDTH-1:0]        data;
    logic                        o;
    logic signed [SW-1:0]        v;
    logic                        ok;
    check_mode_t                 chk;
    gled_result_t                want;
  } script_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       op = OP_SAMPLE;
  logic signed [SW-1:0]       sample_value = '0;
  logic                       sample_valid = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ROW_OUT_WIDTH-1:0]   cell_row;
  logic [COL_OUT_WIDTH-1:0]   cell_col;
  logic [KIND_WIDTH-1:0]      kind;
  logic                       frame_last;

  grid_local_extremum_detector_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .kind         (kind),
    .frame_last   (frame_last)
  );

  // grid model state
  logic signed [SW-1:0] line_val [STORE_DEPTH];
  bit                   line_ok  [STORE_DEPTH];
  int unsigned          grid_rows = GRID_DIM_RESET;
  int unsigned          grid_cols = GRID_DIM_RESET;
  int unsigned          grid_in_row = 0;
  int unsigned          grid_in_col = 0;
  int unsigned          next_cell = 0;

  gled_result_t pending_cells [$];
  script_row_t  script [$];

  int unsigned cycle_count = 0;
  int error_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int minima_seen = 0;
  int maxima_seen = 0;
  int frames_seen = 0;
  int random_beats = 0;
  int phase = 0;
  bit steady_in = 0;
  bit steady_out = 0;
  bit paused_once = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_local_extremum_detector_core] ERROR");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [CFG_WIDTH-1:0] raw,
                                            input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return 32'(raw);
  endfunction

  function automatic gled_result_t typed_cell(input int r, input int c,
                                              input logic [KIND_WIDTH-1:0] k,
                                              input logic l);
    gled_result_t res;
    res.cell_row   = ROW_OUT_WIDTH'(r);
    res.cell_col   = COL_OUT_WIDTH'(c);
    res.kind       = k;
    res.frame_last = l;
    return res;
  endfunction

  function automatic void restart_frame();
    grid_in_row = 0;
    grid_in_col = 0;
    next_cell   = 0;
  endfunction

  task automatic compare_neighbor(input int unsigned pos, input logic signed [SW-1:0] me,
                                  inout bit lo, inout bit hi);
    if (line_ok[pos % STORE_DEPTH]) begin
      if (!(me < line_val[pos % STORE_DEPTH])) lo = 0;
      if (!(me > line_val[pos % STORE_DEPTH])) hi = 0;
    end
  endtask

  task automatic classify_cell(output gled_result_t res);
    int unsigned c, r, col;
    bit lo, hi;
    logic signed [SW-1:0] me;
    c   = next_cell;
    r   = c / grid_cols;
    col = c % grid_cols;
    lo  = 1;
    hi  = 1;
    res.kind = KIND_NONE;
    if (line_ok[c % STORE_DEPTH]) begin
      me = line_val[c % STORE_DEPTH];
      if (r > 0) compare_neighbor(c - grid_cols, me, lo, hi);
      if (r + 1 < grid_rows) compare_neighbor(c + grid_cols, me, lo, hi);
      if (col > 0) compare_neighbor(c - 1, me, lo, hi);
      if (col + 1 < grid_cols) compare_neighbor(c + 1, me, lo, hi);
      if (lo) res.kind = KIND_MIN;
      else if (hi) res.kind = KIND_MAX;
    end
    res.cell_row   = ROW_OUT_WIDTH'(r);
    res.cell_col   = COL_OUT_WIDTH'(col);
    res.frame_last = (c + 1 == grid_rows * grid_cols);
    next_cell = c + 1;
    if (res.frame_last) restart_frame();
  endtask

  task automatic step_grid(input logic o, input logic signed [SW-1:0] v, input logic ok,
                           output bit took, output bit has, output gled_result_t res);
    int unsigned k;
    bit full;
    took = 0;
    has  = 0;
    res  = '0;
    full = (grid_in_row >= grid_rows);
    if (o == OP_SAMPLE) begin
      if (!full) begin
        took = 1;
        k = grid_in_row * grid_cols + grid_in_col;
        line_val[k % STORE_DEPTH] = v;
        line_ok[k % STORE_DEPTH]  = ok;
        grid_in_col++;
        if (grid_in_col >= grid_cols) begin
          grid_in_col = 0;
          grid_in_row++;
        end
        if (k >= grid_cols) begin
          has = 1;
          classify_cell(res);
        end
      end
    end else if (full) begin
      took = 1;
      has  = 1;
      classify_cell(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic send_beat(input logic o, input logic signed [SW-1:0] v, input logic ok,
                           input check_mode_t chk, input gled_result_t want,
                           output bit took);
    int w;
    bit has;
    gled_result_t res;
    w = steady_in ? 0 : $urandom_range(0, 7);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    sample_value <= v;
    sample_valid <= ok;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
    step_grid(o, v, ok, took, has, res);
    if (chk == CHK_TYPED) pending_cells.insert(pending_cells.size(), want);
    else if (chk == CHK_MODEL && has) pending_cells.insert(pending_cells.size(), res);
  endtask

  // drop valid, wait for every pending cell, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_GRID_ROWS) begin
      grid_rows = clamp_dim(data, MAX_ROWS_DEF);
      restart_frame();
    end else if (idx == REG_GRID_COLS) begin
      grid_cols = clamp_dim(data, MAX_COLS_DEF);
      restart_frame();
    end
    @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] random_sample(input int vmode);
    case (vmode)
      0: return SW'($signed($urandom_range(0, 6)) - 3);
      1: return SW'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0: return VALUE_MIN;
          1: return VALUE_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_WIDTH-1:0] data);
    script_row_t row;
    row.is_cfg = 1;
    row.idx    = idx;
    row.data   = data;
    row.o      = OP_SAMPLE;
    row.v      = '0;
    row.ok     = 1'b0;
    row.chk    = CHK_NONE;
    row.want   = '0;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_beat(input logic o, input logic signed [SW-1:0] v,
                                   input logic ok, input check_mode_t chk,
                                   input gled_result_t want);
    script_row_t row;
    row.is_cfg = 0;
    row.idx    = '0;
    row.data   = '0;
    row.o      = o;
    row.v      = v;
    row.ok     = ok;
    row.chk    = chk;
    row.want   = want;
    script.insert(script.size(), row);
  endfunction

  task automatic run_frame(input bit cut, input bit big);
    int budget, vmode;
    bit took;
    vmode  = big ? 0 : $urandom_range(0, 2);
    if (big) budget = BIG_BUDGET;
    else budget = cut ? $urandom_range(1, grid_rows * grid_cols) : -1;
    while (grid_in_row < grid_rows && budget != 0) begin
      if (!big && $urandom_range(0, 15) == 0)
        send_beat(OP_FLUSH, random_sample(1), 1'($urandom_range(0, 1)), CHK_MODEL, '0,
                  took);
      if (!paused_once && random_beats >= PAUSE_AT) begin
        paused_once = 1;
        settle();
      end
      send_beat(OP_SAMPLE, random_sample(vmode), $urandom_range(0, 7) != 0, CHK_MODEL,
                '0, took);
      if (took && !big) random_beats++;
      budget--;
    end
    while (grid_in_row >= grid_rows && budget != 0) begin
      if (!big && $urandom_range(0, 15) == 0)
        send_beat(OP_SAMPLE, random_sample(1), 1'($urandom_range(0, 1)), CHK_MODEL, '0,
                  took);
      send_beat(OP_FLUSH, random_sample(1), 1'($urandom_range(0, 1)), CHK_MODEL, '0, took);
      if (took && !big) random_beats++;
    end
  endtask

  initial begin : result_sink
    int w, held;
    bit hold_done;
    gled_result_t want;
    hold_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT && in_valid === 1'b1) begin
        hold_done = 1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_LEN; held++) @(posedge clk);
      end else begin
        w = steady_out ? 0 : $urandom_range(0, 7);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("no pending cell for row %0d col %0d", cell_row, cell_col));
      end else begin
        want = pending_cells.pop_front();
        if (cell_row !== want.cell_row)
          report_mismatch($sformatf("cell_row %0d, want %0d", cell_row, want.cell_row));
        if (cell_col !== want.cell_col)
          report_mismatch($sformatf("cell_col %0d, want %0d", cell_col, want.cell_col));
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last %0d, want %0d", frame_last, want.frame_last));
      end
      results_seen++;
      if (kind == KIND_MIN) minima_seen++;
      if (kind == KIND_MAX) maxima_seen++;
      if (frame_last === 1'b1) frames_seen++;
    end
  end

  initial begin : stimulus
    bit took, was_big, big;
    int nframes;
    script_row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset grid is 1024 x 1024: early flush and first-row sample give nothing
    add_beat(OP_FLUSH, '0, 1'b0, CHK_NONE, '0);
    add_beat(OP_SAMPLE, VALUE_MIN, 1'b1, CHK_NONE, '0);
    add_cfg(REG_GRID_ROWS, 11'd3);
    add_cfg(REG_GRID_COLS, 11'd3);
    add_beat(OP_SAMPLE, 24'sd5, 1'b1, CHK_NONE, '0);
    add_beat(OP_SAMPLE, VALUE_MIN, 1'b1, CHK_NONE, '0);
    add_beat(OP_FLUSH, '0, 1'b1, CHK_NONE, '0);
    add_beat(OP_SAMPLE, 24'sd5, 1'b1, CHK_NONE, '0);
    add_beat(OP_SAMPLE, VALUE_MAX, 1'b1, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, '0, 1'b0, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, 24'sd3, 1'b1, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, 24'sd3, 1'b1, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, 24'sd3, 1'b1, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, 24'sd7, 1'b1, CHK_MODEL, '0);
    add_beat(OP_SAMPLE, 24'sd1, 1'b1, CHK_NONE, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_MODEL, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_MODEL, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_MODEL, '0);
    // zero dimensions clamp to a single cell with no neighbours
    add_cfg(REG_GRID_ROWS, 11'd0);
    add_cfg(REG_GRID_COLS, 11'd0);
    add_beat(OP_SAMPLE, 24'sd100, 1'b1, CHK_NONE, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_TYPED, typed_cell(0, 0, KIND_MIN, 1'b1));
    add_beat(OP_SAMPLE, 24'sd100, 1'b0, CHK_NONE, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_TYPED, typed_cell(0, 0, KIND_NONE, 1'b1));
    add_cfg(REG_SPARE_B, 11'h7FF);
    add_beat(OP_SAMPLE, '1, 1'b1, CHK_NONE, '0);
    add_beat(OP_FLUSH, '0, 1'b0, CHK_TYPED, typed_cell(0, 0, KIND_MIN, 1'b1));

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_beat(row.o, row.v, row.ok, row.chk, row.want, took);
      end
    end

    was_big = 0;
    while (beats_sent < ITEM_TARGET) begin
      phase++;
      big = 0;
      settle();
      steady_in  = ($urandom_range(0, 4) == 0);
      steady_out = ($urandom_range(0, 4) == 0);
      if (phase == WIDE_PHASE) begin
        write_reg(REG_GRID_ROWS, 11'd0);
        write_reg(REG_GRID_COLS, 11'h7FF);
        big = 1;
      end else if (phase == TALL_PHASE) begin
        write_reg(REG_GRID_ROWS, 11'h7FF);
        write_reg(REG_GRID_COLS, 11'd0);
        big = 1;
      end else if (was_big || $urandom_range(0, 4) != 0) begin
        if (was_big || $urandom_range(0, 3) != 0)
          write_reg(REG_GRID_ROWS, CFG_WIDTH'($urandom_range(1, 6)));
        write_reg(REG_GRID_COLS,
                  ($urandom_range(0, 7) == 0) ? CFG_WIDTH'($urandom_range(9, 32))
                                              : CFG_WIDTH'($urandom_range(1, 8)));
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_SPARE_A, REG_SPARE_B)),
                  CFG_WIDTH'($urandom_range(0, 2047)));
      nframes = big ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++)
        run_frame(!big && f == nframes - 1 && $urandom_range(0, 4) == 0, big);
      was_big = big;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d input beats over %0d random phases, wide and tall frames included",
             beats_sent, phase);
    $display("checked %0d result beats: %0d minima, %0d maxima, %0d complete frames",
             results_seen, minima_seen, maxima_seen, frames_seen);
    if (error_count == 0) begin
      $display("[grid_local_extremum_detector_core] OK");
    end else begin
      $display("[grid_local_extremum_detector_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gled_pkg.sv
rtl/core/gled_line_ram.sv
rtl/core/gled_classify.sv
rtl/core/gled_out_fifo.sv
rtl/core/grid_local_extremum_detector_core.sv
bench/tb_grid_local_extremum_detector_core.sv
